[src/tms_pkg.sv]
// Package for the trimmed mean sampler: widths, limits, the job record passed from
// the front end to the divider, and the divider state type.
// No dependencies.
package tms_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int COUNT_BITS   = 8;
    localparam int MAX_COUNT    = 255;
    localparam int SUM_BITS     = 18;
    localparam int MIN_COUNT    = 3;
    localparam int TRIM_COUNT   = 2;
    localparam int COUNT_RESET  = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_STEPS    = SUM_BITS;
    localparam int STEP_BITS    = $clog2(DIV_STEPS);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [SUM_BITS-1:0]    sum_t;

    typedef struct packed {
        logic   error;
        sum_t   trimmed;
        count_t divisor;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIVIDE,
        BACK_OUTPUT
    } back_state_t;

endpackage

[src/tms_sample_if.sv]
// Sample channel of the trimmed mean sampler.
// Depends on tms_pkg.
interface tms_sample_if
    import tms_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

[src/tms_result_if.sv]
// Result channel of the trimmed mean sampler.
// Depends on tms_pkg.
interface tms_result_if
    import tms_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t average;
    logic    error;

    modport source (output valid, output average, output error, input ready);
    modport sink (input valid, input average, input error, output ready);
endinterface

[src/tms_count_if.sv]
// Configuration write channel carrying the batch sample count.
// Depends on tms_pkg.
interface tms_count_if
    import tms_pkg::*;
();
    logic   valid;
    logic   ready;
    count_t sample_count;

    modport source (output valid, output sample_count, input ready);
    modport sink (input valid, input sample_count, output ready);
endinterface

[src/tms_front.sv]
// Front end: takes sample beats, keeps the batch sum and extremes and issues a job
// at the end of each batch or on a bad count. Depends on tms_pkg and the interfaces.
module tms_front
    import tms_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tms_count_if.sink     cfg,
    tms_sample_if.sink    samples,
    input  queue_status_t qstat,
    output logic          push,
    output job_t          push_job
);

    count_t  count_reg, count_next;
    count_t  seen_reg, seen_next;
    sum_t    sum_reg, sum_next;
    sample_t min_reg, min_next;
    sample_t max_reg, max_next;

    logic    accept;
    sample_t upd_min, upd_max;
    sum_t    upd_sum;
    count_t  upd_seen;

    assign cfg.ready     = 1'b1;
    assign samples.ready = !qstat.full && !cfg.valid;
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        upd_seen = seen_reg + count_t'(1);
        upd_sum  = sum_reg + sum_t'(samples.sample);
        if (seen_reg == '0)
        begin
            upd_min = samples.sample;
            upd_max = samples.sample;
        end
        else
        begin
            upd_min = (samples.sample < min_reg) ? samples.sample : min_reg;
            upd_max = (samples.sample > max_reg) ? samples.sample : max_reg;
        end
    end

    always_comb
    begin
        count_next       = count_reg;
        seen_next        = seen_reg;
        sum_next         = sum_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        push             = 1'b0;
        push_job.error   = 1'b0;
        push_job.trimmed = upd_sum - sum_t'(upd_min) - sum_t'(upd_max);
        push_job.divisor = count_reg - count_t'(TRIM_COUNT);
        priority if (cfg.valid)
        begin
            count_next = cfg.sample_count;
            seen_next  = '0;
            sum_next   = '0;
            min_next   = '0;
            max_next   = '0;
        end
        else if (accept)
        begin
            if (count_reg < count_t'(MIN_COUNT))
            begin
                push           = 1'b1;
                push_job.error = 1'b1;
                seen_next      = '0;
                sum_next       = '0;
                min_next       = '0;
                max_next       = '0;
            end
            else if (upd_seen == count_reg)
            begin
                push      = 1'b1;
                seen_next = '0;
                sum_next  = '0;
                min_next  = '0;
                max_next  = '0;
            end
            else
            begin
                seen_next = upd_seen;
                sum_next  = upd_sum;
                min_next  = upd_min;
                max_next  = upd_max;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= count_t'(COUNT_RESET);
            seen_reg  <= '0;
            sum_reg   <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            seen_reg  <= seen_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

endmodule

[src/tms_queue.sv]
// Short job queue between the front end and the divider.
// Depends on tms_pkg.
module tms_queue
    import tms_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          head_job,
    output queue_status_t qstat
);

    job_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] fill_reg, fill_next;
    logic                 do_push, do_pop;

    assign qstat.full  = (fill_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign qstat.empty = (fill_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head_job    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_BITS'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + QCNT_BITS'(1);
            2'b01:   fill_next = fill_reg - QCNT_BITS'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[src/tms_back.sv]
// Back end: takes jobs from the queue, runs a one-bit-per-cycle restoring divider
// and holds the result beat until it is taken. Depends on tms_pkg and tms_result_if.
module tms_back
    import tms_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  job_t          head_job,
    input  queue_status_t qstat,
    output logic          pop,
    tms_result_if.source  results
);

    back_state_t          state_reg, state_next;
    sum_t                 quo_reg;
    count_t               rem_reg;
    count_t               div_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 err_reg;
    logic [COUNT_BITS:0]  partial;
    logic                 fits;
    logic                 last_step;

    assign partial   = {rem_reg, quo_reg[SUM_BITS-1]};
    assign fits      = (partial >= {1'b0, div_reg});
    assign last_step = (step_reg == STEP_BITS'(DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = head_job.error ? BACK_OUTPUT : BACK_DIVIDE;
                end
            end
            BACK_DIVIDE:
            begin
                if (last_step)
                begin
                    state_next = BACK_OUTPUT;
                end
            end
            BACK_OUTPUT:
            begin
                if (results.ready)
                begin
                    state_next = BACK_IDLE;
                end
            end
            default: state_next = BACK_IDLE;
        endcase
    end

    always_comb
    begin
        pop             = (state_reg == BACK_IDLE) && !qstat.empty;
        results.valid   = (state_reg == BACK_OUTPUT);
        results.error   = err_reg;
        results.average = err_reg ? '0 : quo_reg[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            quo_reg  <= head_job.trimmed;
            rem_reg  <= '0;
            div_reg  <= head_job.divisor;
            step_reg <= '0;
            err_reg  <= head_job.error;
        end
        else if (state_reg == BACK_DIVIDE)
        begin
            quo_reg  <= {quo_reg[SUM_BITS-2:0], fits};
            rem_reg  <= fits ? COUNT_BITS'(partial - {1'b0, div_reg})
                             : partial[COUNT_BITS-1:0];
            step_reg <= step_reg + STEP_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BACK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/trimmed_mean_sampler.sv]
// Trimmed mean sampler: top level joining front end, job queue and divider.
// Depends on tms_pkg, the channel interfaces, tms_front, tms_queue and tms_back.
//
// Samples are taken one beat per cycle while the job queue has room and no count
// write is offered; a sample that does not close a batch is absorbed in that cycle.
// The closing sample of a batch becomes a job for the divider, which loads it from
// the queue, divides and then presents the result until it is taken. With a count
// below three each sample gives an error beat, which skips the division. A two-entry
// job queue lets sampling continue while the divider works or a result waits to be
// taken. Writing the count restarts the batch.
module trimmed_mean_sampler
    import tms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tms_count_if.sink    cfg,
    tms_sample_if.sink   samples,
    tms_result_if.source results
);

    queue_status_t qstat;
    logic          push;
    logic          pop;
    job_t          push_job;
    job_t          head_job;

    tms_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .samples  (samples),
        .qstat    (qstat),
        .push     (push),
        .push_job (push_job)
    );

    tms_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    tms_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .qstat    (qstat),
        .pop      (pop),
        .results  (results)
    );

endmodule

[src/tms_checker.sv]
// Port-level checks on the trimmed mean sampler result channel.
// Depends on tms_pkg; bound to trimmed_mean_sampler.
module tms_checker
    import tms_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    res_valid,
    input logic    res_ready,
    input sample_t res_average,
    input logic    res_error
);

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_average) && $stable(res_error))
        else $error("Result beat changed while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_error |-> res_average == '0)
        else $error("Error beat carries a non-zero average.");

    assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("Result beat shown on leaving reset.");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_error |=> !(res_valid && !res_error))
        else $error("Two batch averages in consecutive cycles.");

endmodule

bind trimmed_mean_sampler tms_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (results.valid),
    .res_ready   (results.ready),
    .res_average (results.average),
    .res_error   (results.error)
);

[test/tms_average_checker.sv]
`timescale 1ns / 100ps
// Checker for the trimmed mean sampler: watches the count, sample and result channels,
// predicts each average beat and compares it with what the block delivers.
// Depends on tms_pkg and the three channel interfaces.
module tms_average_checker
    import tms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    tms_count_if  cfg,
    tms_sample_if samples,
    tms_result_if results,
    output int    mismatches,
    output int    pending
);

    typedef struct packed {
        logic    error;
        sample_t average;
    } avg_beat_t;

    avg_beat_t averages_due[$];
    count_t    batch_len;
    count_t    batch_fill;
    sum_t      batch_sum;
    sample_t   batch_low;
    sample_t   batch_high;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic clear_batch();
        batch_fill = '0;
        batch_sum  = '0;
        batch_low  = '0;
        batch_high = '0;
    endtask

    task automatic take_sample(input sample_t s);
        avg_beat_t beat;
        sum_t      trimmed;
        if (batch_len < count_t'(MIN_COUNT))
        begin
            clear_batch();
            beat.error   = 1'b1;
            beat.average = '0;
            averages_due.push_back(beat);
            return;
        end
        if (batch_fill == 0)
        begin
            batch_low  = s;
            batch_high = s;
        end
        else
        begin
            if (s < batch_low)
                batch_low = s;
            if (s > batch_high)
                batch_high = s;
        end
        batch_sum  = batch_sum + sum_t'(s);
        batch_fill = batch_fill + count_t'(1);
        if (batch_fill >= batch_len)
        begin
            trimmed      = batch_sum - sum_t'(batch_low) - sum_t'(batch_high);
            beat.error   = 1'b0;
            beat.average = sample_t'(trimmed / (sum_t'(batch_fill) - sum_t'(TRIM_COUNT)));
            averages_due.push_back(beat);
            clear_batch();
        end
    endtask

    task automatic check_beat(input sample_t average, input logic error);
        avg_beat_t want;
        if (averages_due.size() == 0)
        begin
            report_mismatch($sformatf("beat with nothing due, average %0d error %0b",
                                      average, error));
            return;
        end
        want = averages_due.pop_front();
        if (error !== want.error)
            report_mismatch($sformatf("error got %0b, expected %0b", error, want.error));
        if (average !== want.average)
            report_mismatch($sformatf("average got %0d, expected %0d",
                                      average, want.average));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_len = count_t'(COUNT_RESET);
            clear_batch();
            averages_due.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                batch_len = cfg.sample_count;
                clear_batch();
            end
            if (samples.valid && samples.ready)
                take_sample(samples.sample);
            if (results.valid && results.ready)
                check_beat(results.average, results.error);
            pending <= averages_due.size();
        end
    end

endmodule

[test/tb_trimmed_mean_sampler.sv]
`timescale 1ns / 100ps
// Testbench top for the trimmed mean sampler: drives counts and samples in bursts,
// stalls the result side and gives the verdict from the checker's mismatch count.
// Depends on tms_pkg, the channel interfaces, trimmed_mean_sampler and tms_average_checker.
module tb_trimmed_mean_sampler;
    import tms_pkg::*;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   burst_left = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   pattern_age = 0;
    logic [15:0] stall_pattern = 16'hFFFF;

    tms_count_if  cfg_ch();
    tms_sample_if sample_ch();
    tms_result_if result_ch();

    trimmed_mean_sampler uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (sample_ch),
        .results (result_ch)
    );

    tms_average_checker average_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .samples    (sample_ch),
        .results    (result_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_done)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else
        begin
            result_ch.ready <= stall_pattern[0];
        end
        if (pattern_age == 63)
        begin
            pattern_age <= 0;
            if ($urandom_range(0, 3) == 0)
                stall_pattern <= 16'hFFFF;
            else
                stall_pattern <= 16'($urandom()) | 16'h8421;
        end
        else
        begin
            pattern_age <= pattern_age + 1;
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    function automatic sample_t rand_sample(input bit lean_high);
        int pick;
        pick = $urandom_range(0, 7);
        if (lean_high)
            return (pick == 0) ? sample_t'($urandom_range(0, 1023)) : '1;
        case (pick)
            0: return '0;
            1: return '1;
            default: return sample_t'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic send_sample(input sample_t value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_count(input count_t value);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.sample_count <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_averages();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    initial
    begin
        sample_t reset_batch[8] = '{1023, 0, 512, 511, 1, 1022, 341, 682};
        sample_t edge_batches[9] = '{0, 0, 0, 1023, 1023, 1023, 1023, 0, 1000};
        sample_t spread_batch[4] = '{10, 20, 30, 40};
        count_t  count;
        int      pick;
        int      phase;
        int      sent;
        int      n_items;
        int      batches;

        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.sample_count = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.sample    = '0;
        result_ch.ready     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (reset_batch[i])
            send_sample(reset_batch[i]);
        drain_averages();
        write_count(count_t'(MIN_COUNT));
        foreach (edge_batches[i])
            send_sample(edge_batches[i]);
        drain_averages();
        write_count(count_t'(2));
        send_sample('1);
        drain_averages();
        write_count('0);
        send_sample('0);
        drain_averages();
        write_count(count_t'(1));
        send_sample(sample_t'(5));
        drain_averages();
        write_count(count_t'(4));
        send_sample(sample_t'(1));
        drain_averages();
        write_count(count_t'(4));
        foreach (spread_batch[i])
            send_sample(spread_batch[i]);

        sent = 0;
        for (phase = 0; sent < 900; phase++)
        begin
            drain_averages();
            if (phase == 0)
                count = count_t'(MIN_COUNT);
            else if (phase == 1)
                count = count_t'(MAX_COUNT);
            else
            begin
                pick = $urandom_range(0, 19);
                if (pick < 2)
                    count = count_t'($urandom_range(0, 2));
                else if (pick < 5)
                    count = count_t'(MIN_COUNT);
                else if (pick < 14)
                    count = count_t'($urandom_range(4, 12));
                else if (pick < 19)
                    count = count_t'($urandom_range(13, 40));
                else
                    count = count_t'($urandom_range(41, 254));
            end
            write_count(count);
            if (phase == 0)
            begin
                hold_go <= 1'b1;
                n_items = 90;
            end
            else if (count < count_t'(MIN_COUNT))
            begin
                n_items = $urandom_range(5, 30);
            end
            else
            begin
                batches = $urandom_range(1, (count > 60) ? 1 : 60 / count);
                n_items = batches * count;
                if (phase > 1 && $urandom_range(0, 3) == 0)
                    n_items += $urandom_range(1, count - 1);
            end
            if (n_items > 900 - sent)
                n_items = 900 - sent;
            for (int i = 0; i < n_items; i++)
            begin
                send_sample(rand_sample(phase == 1));
                sent++;
            end
        end

        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[trimmed_mean_sampler.f]
src/tms_pkg.sv
src/tms_sample_if.sv
src/tms_result_if.sv
src/tms_count_if.sv
src/tms_front.sv
src/tms_queue.sv
src/tms_back.sv
src/trimmed_mean_sampler.sv
src/tms_checker.sv
test/tms_average_checker.sv
test/tb_trimmed_mean_sampler.sv
